/* sv/dbs_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the disc brush stamp rasterizer.
// No dependencies; dbs_fb, dbs_falloff and the top module import this package.
package dbs_pkg;

  localparam logic [1:0] MODE_HARD   = 2'd0;
  localparam logic [1:0] MODE_SMOOTH = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_OUTSIDE = 1'b1;

  localparam int unsigned CFG_W    = 9;
  localparam int unsigned CFG_RESET = 256;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  localparam pixel_t PIXEL_WHITE = '{red: 8'hFF, green: 8'hFF, blue: 8'hFF, alpha: 8'hFF};
  localparam pixel_t PIXEL_ZERO  = '{red: 8'h00, green: 8'h00, blue: 8'h00, alpha: 8'h00};

endpackage

/* sv/dbs_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the stamp request and result words.
// No dependencies.
interface dbs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] pos_x;
  logic [7:0] pos_y;
  logic [5:0] radius;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  modport source (output valid, mode, pos_x, pos_y, radius, red, green, blue, alpha,
                  input ready);
  modport sink (input valid, mode, pos_x, pos_y, radius, red, green, blue, alpha,
                output ready);
endinterface

interface dbs_out_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;
  logic [7:0] pixel_alpha;
  modport source (output valid, status, pixel_red, pixel_green, pixel_blue, pixel_alpha,
                  input ready);
  modport sink (input valid, status, pixel_red, pixel_green, pixel_blue, pixel_alpha,
                output ready);
endinterface

/* sv/dbs_fb.sv */
`timescale 1ns / 1ps
// Framebuffer memory: single port, registered read, white clearing pass after reset.
// Depends on dbs_pkg.
module dbs_fb import dbs_pkg::*; #(
  parameter int unsigned ADDR_W = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  output logic              busy_o,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  pixel_t            wdata_i,
  output pixel_t            rdata_o
);

  pixel_t mem [2**ADDR_W];

  logic              clr_q;
  logic [ADDR_W-1:0] clr_addr_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  pixel_t            mem_wdata;
  pixel_t            rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + ADDR_W'(1);
      if (clr_addr_q == {ADDR_W{1'b1}}) begin
        clr_q <= 1'b0;
      end
    end
  end

  always_comb begin
    mem_we    = clr_q | we_i;
    mem_addr  = clr_q ? clr_addr_q : addr_i;
    mem_wdata = clr_q ? PIXEL_WHITE : wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem[mem_addr];
  end

  assign busy_o  = clr_q;
  assign rdata_o = rdata_q;

endmodule

/* sv/dbs_falloff.sv */
`timescale 1ns / 1ps
// Smooth-mode alpha unit: bit-serial square root of the scaled squared distance,
// one multiply, then an eight-step restoring division. Depends on dbs_pkg.
module dbs_falloff import dbs_pkg::*; #(
  parameter int unsigned RW = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [2*RW:0]   d2_i,
  input  logic [RW-1:0]   radius_i,
  input  logic [7:0]      alpha_i,
  output logic            done_o,
  output logic [7:0]      alpha_o
);

  localparam int unsigned SQW = RW + 8;
  localparam int unsigned VW  = 2 * SQW;
  localparam int unsigned NW  = RW + 16;
  localparam int unsigned CNW = $clog2(SQW + 1);

  typedef enum logic [1:0] {F_IDLE, F_SQRT, F_MUL, F_DIV} fstate_e;

  fstate_e          state_q;
  logic [VW-1:0]    v_q;
  logic [SQW+2:0]   rem_q;
  logic [SQW-1:0]   root_q;
  logic [SQW-1:0]   scale_q;
  logic [7:0]       a_q;
  logic [CNW-1:0]   cnt_q;
  logic [NW-1:0]    num_q;
  logic [2:0]       k_q;
  logic [7:0]       quo_q;
  logic             done_q;
  logic [7:0]       alpha_q;

  logic [SQW+2:0]   rem_sh;
  logic [SQW+2:0]   trial;
  logic             take;
  logic [NW-1:0]    sub;
  logic             fit;

  always_comb begin
    rem_sh = {rem_q[SQW:0], v_q[VW-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    take   = rem_sh >= trial;
    sub    = NW'(scale_q) << k_q;
    fit    = num_q >= sub;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      done_q  <= 1'b0;
      v_q     <= '0;
      rem_q   <= '0;
      root_q  <= '0;
      scale_q <= '0;
      a_q     <= '0;
      cnt_q   <= '0;
      num_q   <= '0;
      k_q     <= '0;
      quo_q   <= '0;
      alpha_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        F_IDLE: begin
          if (start_i) begin
            v_q     <= {d2_i[2*RW-1:0], 16'h0000};
            rem_q   <= '0;
            root_q  <= '0;
            scale_q <= {radius_i, 8'h00};
            a_q     <= alpha_i;
            cnt_q   <= CNW'(SQW - 1);
            state_q <= F_SQRT;
          end
        end
        F_SQRT: begin
          rem_q  <= take ? rem_sh - trial : rem_sh;
          root_q <= {root_q[SQW-2:0], take};
          v_q    <= v_q << 2;
          cnt_q  <= cnt_q - CNW'(1);
          if (cnt_q == '0) begin
            state_q <= F_MUL;
          end
        end
        F_MUL: begin
          num_q   <= NW'(a_q) * NW'(scale_q - root_q);
          k_q     <= 3'd7;
          quo_q   <= '0;
          state_q <= F_DIV;
        end
        F_DIV: begin
          if (fit) begin
            num_q <= num_q - sub;
          end
          quo_q <= {quo_q[6:0], fit};
          k_q   <= k_q - 3'd1;
          if (k_q == 3'd0) begin
            alpha_q <= {quo_q[6:0], fit};
            done_q  <= 1'b1;
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  assign done_o  = done_q;
  assign alpha_o = alpha_q;

endmodule

/* sv/disc_brush_stamp_rasterizer_top.sv */
`timescale 1ns / 1ps
// Disc brush stamp rasterizer: stamps hard or alpha-falloff discs into a framebuffer
// and reads back single pixels. Depends on dbs_pkg, dbs_if, dbs_fb and dbs_falloff.
// A read returns the stored pixel at the request position; a stamp walks the clipped
// (2r)^2 box row by row, and in smooth mode each covered pixel waits for the square
// root and the division of the falloff unit. Items are taken one at a time.
// Reset: the framebuffer (65536 entries by default) is swept to opaque white, during
// which no word is accepted; size registers reset to 256.
module disc_brush_stamp_rasterizer_top import dbs_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned MAX_RADIUS = 63
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  dbs_in_if.sink            in_i,
  dbs_out_if.source         out_o
);

  // Address and coordinate widths follow from the store dimensions and the maximum radius.
  localparam int unsigned ADDR_W = (MAX_WIDTH * MAX_HEIGHT > 1) ?
                                   $clog2(MAX_WIDTH * MAX_HEIGHT) : 1;
  localparam int unsigned RW  = $clog2(MAX_RADIUS + 1);
  localparam int unsigned CW  = $clog2(MAX_WIDTH + MAX_HEIGHT + 2 * MAX_RADIUS + 512) + 1;
  localparam int unsigned D2W = 2 * RW + 1;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_WALK, S_SHADE, S_DONE} state_e;

  // Size registers, to be written only while the block is idle; the block itself does not enforce it.
  logic [CFG_W-1:0] width_q;
  logic [CFG_W-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(CFG_RESET);
      height_q <= CFG_W'(CFG_RESET);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_WIDTH:  width_q  <= cfg_data_i;
        CFG_IDX_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective image box, saturated to the store size.
  logic signed [CW-1:0] w_eff;
  logic signed [CW-1:0] h_eff;

  always_comb begin
    w_eff = (int'(width_q) > int'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(width_q);
    h_eff = (int'(height_q) > int'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(height_q);
  end

  state_e               state_q;
  logic [1:0]           mode_q;
  logic signed [CW-1:0] cx_q, cy_q;
  logic [RW-1:0]        r_q;
  pixel_t               color_q;
  logic signed [CW-1:0] x_q, y_q, x0_q, x1_q, y1_q;
  logic                 res_status_q;
  pixel_t               res_pix_q;
  logic                 out_valid_q;
  logic                 out_status_q;
  pixel_t               out_pix_q;

  logic                 fb_busy;
  logic                 fb_we;
  logic [ADDR_W-1:0]    fb_addr;
  pixel_t               fb_wdata;
  pixel_t               fb_rdata;
  logic                 fo_start;
  logic                 fo_done;
  logic [7:0]           fo_alpha;

  // Request decode in the accepting cycle.
  logic                 accept;
  logic signed [CW-1:0] in_cx, in_cy, in_x0, in_x1, in_y0, in_y1;
  logic [RW-1:0]        in_r;
  logic signed [CW-1:0] in_rs;
  logic                 in_pos_ok;
  logic                 in_mode_known;

  always_comb begin
    accept        = in_i.valid && in_i.ready;
    in_cx         = CW'(in_i.pos_x);
    in_cy         = CW'(in_i.pos_y);
    in_r          = (int'(in_i.radius) > int'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(in_i.radius);
    in_rs         = CW'(in_r);
    in_pos_ok     = (in_cx < w_eff) && (in_cy < h_eff);
    in_mode_known = (in_i.mode == MODE_HARD) || (in_i.mode == MODE_SMOOTH) ||
                    (in_i.mode == MODE_READ);
    in_x0         = (in_cx - in_rs < 0) ? '0 : in_cx - in_rs;
    in_y0         = (in_cy - in_rs < 0) ? '0 : in_cy - in_rs;
    in_x1         = (in_cx + in_rs > w_eff) ? w_eff : in_cx + in_rs;
    in_y1         = (in_cy + in_rs > h_eff) ? h_eff : in_cy + in_rs;
  end

  // Per-pixel distance test of the walker.
  logic signed [CW-1:0] dxs, dys;
  logic [RW-1:0]        dx, dy;
  logic [D2W-1:0]       d2, r2;
  logic                 covered;
  logic                 x_last, y_last;

  always_comb begin
    dxs     = (x_q > cx_q) ? x_q - cx_q : cx_q - x_q;
    dys     = (y_q > cy_q) ? y_q - cy_q : cy_q - y_q;
    dx      = RW'(dxs);
    dy      = RW'(dys);
    d2      = D2W'(dx) * D2W'(dx) + D2W'(dy) * D2W'(dy);
    r2      = D2W'(r_q) * D2W'(r_q);
    covered = d2 < r2;
    x_last  = (x_q + CW'(1)) == x1_q;
    y_last  = (y_q + CW'(1)) == y1_q;
  end

  // Memory port: the read address comes straight from the request, the
  // walker drives the write address.
  always_comb begin
    fb_we    = 1'b0;
    fb_wdata = color_q;
    fo_start = 1'b0;
    if (state_q == S_IDLE) begin
      fb_addr = ADDR_W'($unsigned(in_cy)) * ADDR_W'(MAX_WIDTH) + ADDR_W'($unsigned(in_cx));
    end else begin
      fb_addr = ADDR_W'($unsigned(y_q)) * ADDR_W'(MAX_WIDTH) + ADDR_W'($unsigned(x_q));
    end
    if (state_q == S_WALK && covered) begin
      if (mode_q == MODE_SMOOTH) begin
        fo_start = 1'b1;
      end else begin
        fb_we = 1'b1;
      end
    end
    if (state_q == S_SHADE && fo_done) begin
      fb_we          = 1'b1;
      fb_wdata.alpha = fo_alpha;
    end
  end

  // A pixel step is taken after a hard write or an uncovered pixel, or when
  // the falloff unit hands back the shaded alpha.
  logic step;
  assign step = (state_q == S_WALK && !(covered && mode_q == MODE_SMOOTH)) ||
                (state_q == S_SHADE && fo_done);

  logic out_free;
  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      mode_q       <= MODE_HARD;
      cx_q         <= '0;
      cy_q         <= '0;
      r_q          <= '0;
      color_q      <= PIXEL_ZERO;
      x_q          <= '0;
      y_q          <= '0;
      x0_q         <= '0;
      x1_q         <= '0;
      y1_q         <= '0;
      res_status_q <= STATUS_DONE;
      res_pix_q    <= PIXEL_ZERO;
      out_status_q <= STATUS_DONE;
      out_pix_q    <= PIXEL_ZERO;
    end else begin
      // In S_DONE the output register is reloaded below instead.
      if (out_valid_q && out_o.ready && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            mode_q       <= in_i.mode;
            cx_q         <= in_cx;
            cy_q         <= in_cy;
            r_q          <= in_r;
            color_q      <= '{red: in_i.red, green: in_i.green,
                              blue: in_i.blue, alpha: in_i.alpha};
            x_q          <= in_x0;
            y_q          <= in_y0;
            x0_q         <= in_x0;
            x1_q         <= in_x1;
            y1_q         <= in_y1;
            res_status_q <= (in_mode_known && !in_pos_ok) ? STATUS_OUTSIDE : STATUS_DONE;
            res_pix_q    <= PIXEL_ZERO;
            if (!in_mode_known) begin
              state_q <= S_DONE;
            end else if (!in_pos_ok) begin
              state_q <= S_DONE;
            end else if (in_i.mode == MODE_READ) begin
              state_q <= S_READ;
            end else if (in_x0 >= in_x1 || in_y0 >= in_y1) begin
              state_q <= S_DONE;
            end else begin
              state_q <= S_WALK;
            end
          end
        end
        S_READ: begin
          res_pix_q <= fb_rdata;
          state_q   <= S_DONE;
        end
        S_WALK: begin
          if (!step) begin
            state_q <= S_SHADE;
          end
        end
        S_SHADE: begin
          // On the last pixel the walker below moves on to S_DONE.
          if (fo_done && !(x_last && y_last)) begin
            state_q <= S_WALK;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_pix_q    <= res_pix_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      // Row-major walk over the clipped box; the last pixel ends the stamp.
      if (step) begin
        if (x_last) begin
          x_q <= x0_q;
          y_q <= y_q + CW'(1);
          if (y_last) begin
            state_q <= S_DONE;
          end
        end else begin
          x_q <= x_q + CW'(1);
        end
      end
    end
  end

  dbs_fb #(.ADDR_W(ADDR_W)) u_fb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .busy_o  (fb_busy),
    .we_i    (fb_we),
    .addr_i  (fb_addr),
    .wdata_i (fb_wdata),
    .rdata_o (fb_rdata)
  );

  dbs_falloff #(.RW(RW)) u_falloff (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (fo_start),
    .d2_i     (d2),
    .radius_i (r_q),
    .alpha_i  (color_q.alpha),
    .done_o   (fo_done),
    .alpha_o  (fo_alpha)
  );

  assign in_i.ready        = (state_q == S_IDLE) && !fb_busy;
  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.pixel_red   = out_pix_q.red;
  assign out_o.pixel_green = out_pix_q.green;
  assign out_o.pixel_blue  = out_pix_q.blue;
  assign out_o.pixel_alpha = out_pix_q.alpha;

endmodule
